@@ hw/rtl/sorted_priority_queue_defines.svh @@
// assertion macros for the sorted priority queue
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

`ifndef ASSERT_OFF
// condition must hold at every clock edge out of reset
`define SPQ_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("spq assertion failed");
// consequent must hold in the cycle after the antecedent
`define SPQ_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("spq assertion failed");
`else
`define SPQ_ASSERT(lbl, cond)
`define SPQ_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

@@ hw/rtl/spq_pkg.sv @@
// types and codes shared by the sorted priority queue modules
`timescale 1ns / 1ps

package spq_pkg;

    typedef enum logic [0:0] {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd_code;

    typedef enum logic [1:0] {
        ST_PUSHED = 2'd0,
        ST_FULL   = 2'd1,
        ST_POPPED = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef struct packed {
        logic [0:0]         command;
        logic signed [31:0] data_in;
        logic [15:0]        priority_in;
    } t_cmd;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data_out;
        logic [15:0]        priority_out;
        logic [4:0]         fill_count;
        logic               is_empty;
    } t_res;

    typedef struct packed {
        logic signed [31:0] data;
        logic [15:0]        pri;
    } t_entry;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic   push;
        logic   pop;
        t_entry item;
    } t_cell_ctrl;

endpackage

@@ hw/rtl/spq_chan_if.sv @@
// valid/ready channel carrying one item of payload type t
`timescale 1ns / 1ps

interface spq_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/sorted_priority_queue.sv @@
// top level of the sorted priority queue: controller and cell row
`timescale 1ns / 1ps
`include "sorted_priority_queue_defines.svh"

// sorted priority queue of CAPACITY entries held in a row of cells, one entry
// per cell, in ascending priority order with equal priorities in arrival order.
// a push compares its priority against every cell at once; cells behind the
// insertion point take their left neighbour, the insertion cell takes the new
// entry. a pop shifts every cell one place towards the head. each command
// item gives exactly one result item, registered: the result is offered in the
// cycle after its item is taken, and one item is taken every cycle unless a
// result waits untaken. a waiting result is parted from the input by the output
// register, so a new item is taken in the cycle the result is taken. fill
// count carries the low five bits of the held count.

module sorted_priority_queue import spq_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spq_chan_if.sink    i_cmd,
    spq_chan_if.source  o_res
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] L_CAP = CW'(CAPACITY);

    // control state
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    logic          n_out_valid;
    t_res          r_out;
    t_res          n_out;

    t_cmd          w_cmd;
    logic          w_ready;
    logic          w_accept;
    logic          w_full;
    logic          w_empty;
    logic          w_is_pop;
    t_cell_ctrl    w_ctrl;
    logic [31:0]   w_count_ext;

    t_entry        w_entry [CAPACITY];
    logic          w_gt    [CAPACITY];

    assign w_cmd    = i_cmd.payload;
    // output register frees as its result leaves
    assign w_ready  = !r_out_valid || o_res.ready;
    assign w_accept = i_cmd.valid && w_ready;
    assign w_full   = r_count == L_CAP;
    assign w_empty  = r_count == '0;
    assign w_is_pop = w_cmd.command == CMD_POP;

    assign i_cmd.ready   = w_ready;
    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    assign w_ctrl.push      = w_accept && !w_is_pop && !w_full;
    assign w_ctrl.pop       = w_accept && w_is_pop && !w_empty;
    assign w_ctrl.item.data = w_cmd.data_in;
    assign w_ctrl.item.pri  = w_cmd.priority_in;

    // cell row: cell 0 is the head
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry w_left;
        logic   w_left_gt;
        t_entry w_right;

        if (g == 0) begin : g_head
            assign w_left    = '0;
            assign w_left_gt = 1'b0;
        end else begin : g_mid
            assign w_left    = w_entry[g-1];
            assign w_left_gt = w_gt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_entry[g+1];
        end

        spq_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (w_ctrl),
            .i_count   (r_count),
            .i_left    (w_left),
            .i_left_gt (w_left_gt),
            .i_right   (w_right),
            .o_entry   (w_entry[g]),
            .o_gt      (w_gt[g])
        );
    end

    assign w_count_ext = 32'(n_count);

    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out       = r_out;
        if (w_ctrl.push) begin
            n_count = r_count + 1'b1;
        end else if (w_ctrl.pop) begin
            n_count = r_count - 1'b1;
        end
        if (w_accept) begin
            n_out_valid        = 1'b1;
            n_out.data_out     = '0;
            n_out.priority_out = '0;
            if (w_is_pop) begin
                if (w_empty) begin
                    n_out.status = ST_EMPTY;
                end else begin
                    n_out.status       = ST_POPPED;
                    n_out.data_out     = w_entry[0].data;
                    n_out.priority_out = w_entry[0].pri;
                end
            end else begin
                n_out.status = w_full ? ST_FULL : ST_PUSHED;
            end
            n_out.fill_count = w_count_ext[4:0];
            n_out.is_empty   = n_count == '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    `SPQ_ASSERT(a_count_bound, r_count <= L_CAP)
    `SPQ_ASSERT_NEXT(a_push_grows, w_ctrl.push, r_count == $past(r_count) + 1'b1)
    `SPQ_ASSERT(a_head_sorted, (r_count < CW'(2)) || (w_entry[0].pri <= w_entry[1].pri))
    `SPQ_ASSERT(a_empty_flag, !r_out_valid || (r_out.is_empty == (r_count == '0)))

endmodule

@@ hw/rtl/spq_cell.sv @@
// one slot of the sorted cell row
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic          i_clk,
    input  t_cell_ctrl    i_ctrl,
    input  logic [CW-1:0] i_count,
    input  t_entry        i_left,
    input  logic          i_left_gt,
    input  t_entry        i_right,
    output t_entry        o_entry,
    output logic          o_gt
);

    localparam logic [CW-1:0] L_IDX = CW'(IDX);

    t_entry r_entry;
    t_entry n_entry;
    logic   w_occ;

    assign w_occ = i_count > L_IDX;
    // new item sorts ahead of this slot's entry
    assign o_gt    = w_occ && (r_entry.pri > i_ctrl.item.pri);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.push) begin
            if (i_left_gt) begin
                n_entry = i_left;
            end else if (o_gt || !w_occ) begin
                n_entry = i_ctrl.item;
            end
        end else if (i_ctrl.pop) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

@@ dv/sorted_priority_queue_tb.sv @@
// self-checking testbench for the sorted priority queue: directed and random push/pop traffic
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
    import spq_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int HALF_PERIOD  = 6;
    localparam int STALL_LIMIT  = 2000;   // cycles with no item moving on either side
    localparam int TAIL_CYCLES  = 8;      // results are registered, so this is plenty
    localparam int PHASE_ITEMS  = 435;

    logic i_clk;
    logic i_rst_n;

    spq_chan_if #(.T(t_cmd)) cmd_if ();
    spq_chan_if #(.T(t_res)) res_if ();

    sorted_priority_queue #(.CAPACITY(CAPACITY)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    // entries the queue should hold, head first
    t_entry held_entries[$];
    // results still owed by the block, oldest first
    t_res   pending_results[$];

    int send_idle_pct;
    int recv_stall_pct;
    int error_count;
    int quiet_cycles;

    initial begin
        i_clk = 1'b0;
    end

    always #HALF_PERIOD i_clk = ~i_clk;

    // result side back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        res_if.ready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // sorted insert after every entry of equal or smaller priority, so ties
    // leave in arrival order; pops take the head
    function automatic t_res apply_queue_op(input t_cmd c);
        t_res   r;
        t_entry e;
        int     pos;
        r = '0;
        if (c.command == CMD_PUSH) begin
            if (held_entries.size() >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < held_entries.size() && held_entries[pos].pri <= c.priority_in)
                    pos++;
                e.data = c.data_in;
                e.pri  = c.priority_in;
                held_entries.insert(pos, e);
                r.status = ST_PUSHED;
            end
        end else if (held_entries.size() == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.data_out     = held_entries[0].data;
            r.priority_out = held_entries[0].pri;
            void'(held_entries.pop_front());
            r.status = ST_POPPED;
        end
        r.fill_count = 5'(held_entries.size());
        r.is_empty   = (held_entries.size() == 0);
        return r;
    endfunction

    task automatic check_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            error_count++;
        end
    endtask

    // result checker and watchdog; handshakes are sampled just after the edge,
    // where every signal still holds its pre-edge value
    always @(posedge i_clk) begin
        t_res exp_r;
        t_res act_r;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                act_r = res_if.payload;
                if (pending_results.size() == 0) begin
                    $error("unexpected result item: status %0d", act_r.status);
                    error_count++;
                end else begin
                    exp_r = pending_results.pop_front();
                    check_field("status", exp_r.status, act_r.status);
                    check_field("data_out", exp_r.data_out, act_r.data_out);
                    check_field("priority_out", exp_r.priority_out, act_r.priority_out);
                    check_field("fill_count", exp_r.fill_count, act_r.fill_count);
                    check_field("is_empty", exp_r.is_empty, act_r.is_empty);
                end
            end
            if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // offers one command item, optionally after idle cycles, and records the
    // result it must produce once the block takes it
    task automatic send_cmd(input t_cmd c);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.payload <= c;
        do @(posedge i_clk); while (!cmd_if.ready);
        pending_results.push_back(apply_queue_op(c));
    endtask

    task automatic send_push(input logic signed [31:0] d, input logic [15:0] p);
        t_cmd c;
        c.command     = CMD_PUSH;
        c.data_in     = d;
        c.priority_in = p;
        send_cmd(c);
    endtask

    task automatic send_pop(input logic signed [31:0] d, input logic [15:0] p);
        t_cmd c;
        c.command     = CMD_POP;
        c.data_in     = d;
        c.priority_in = p;
        send_cmd(c);
    endtask

    // priorities drawn from the full range, a narrow band that forces ties,
    // or the extremes
    function automatic logic [15:0] random_prio();
        case ($urandom_range(3))
            0, 1: return 16'($urandom);
            2:    return 16'($urandom_range(7));
            default: begin
                case ($urandom_range(3))
                    0: return 16'h0000;
                    1: return 16'hFFFF;
                    2: return 16'h7FFF;
                    default: return 16'h8000;
                endcase
            end
        endcase
    endfunction

    task automatic set_idling(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    // random traffic in stretches that lean towards filling, draining or
    // neither, so both the full and the empty corner come up often
    task automatic run_random(input int n_items);
        int push_pct;
        int stretch;
        t_cmd c;
        stretch = 0;
        push_pct = 50;
        for (int i = 0; i < n_items; i++) begin
            if (stretch == 0) begin
                stretch = $urandom_range(40, 8);
                case ($urandom_range(2))
                    0: push_pct = 80;
                    1: push_pct = 25;
                    default: push_pct = 50;
                endcase
            end
            stretch--;
            c.command     = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
            c.data_in     = $urandom;
            c.priority_in = random_prio();
            send_cmd(c);
        end
    endtask

    task automatic test_pop_on_empty();
        set_idling(0, 0);
        send_pop(32'sd0, 16'h0000);
        // payload bits on a pop must be ignored
        send_pop(-32'sd1, 16'hFFFF);
    endtask

    task automatic test_extreme_fields();
        set_idling(0, 0);
        send_push(32'sh8000_0000, 16'hFFFF);
        send_push(32'sh7FFF_FFFF, 16'h0000);
        send_push(32'sd0, 16'h8000);
        send_push(-32'sd1, 16'h7FFF);
        repeat (4) send_pop(32'sh5555_5555, 16'hAAAA);
    endtask

    task automatic test_equal_priorities();
        set_idling(0, 0);
        send_push(32'sd1, 16'd5);
        send_push(32'sd2, 16'd5);
        send_push(32'sd3, 16'd5);
        send_push(32'sd9, 16'd4);
        send_push(32'sd4, 16'd5);
        repeat (5) send_pop(32'sd0, 16'd0);
        send_pop(32'sd0, 16'd0);
    endtask

    task automatic test_random_no_idling();
        set_idling(0, 0);
        run_random(PHASE_ITEMS);
    endtask

    task automatic test_random_sender_idle();
        set_idling(63, 0);
        run_random(PHASE_ITEMS);
    endtask

    task automatic test_random_receiver_stall();
        set_idling(0, 63);
        run_random(PHASE_ITEMS);
    endtask

    task automatic test_random_both_idle();
        set_idling(24, 24);
        run_random(PHASE_ITEMS);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        cmd_if.valid   = 1'b0;
        cmd_if.payload = '0;
        res_if.ready   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        error_count    = 0;
        quiet_cycles   = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_pop_on_empty();
        test_extreme_fields();
        test_equal_priorities();
        test_random_no_idling();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();

        cmd_if.valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
        // any stray result in this window is caught by the checker
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
